### rtl/onoff_pkg.sv
// ----------------------------------------------------------------------------
// onoff_pkg: shared types and constants of the on/off server
// Beat formats of both channels, message codes and timing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package onoff_pkg;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_GET       = 2'd1,
    OP_SET       = 2'd2,
    OP_SET_UNACK = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       value;
    logic [7:0] tid;
    logic [15:0] src_addr;
    logic       has_timing;
    logic [7:0] trans_code;
    logic [7:0] delay_code;
  } in_beat_t;

  typedef struct packed {
    logic       led;
    logic       status_valid;
    logic       present;
    logic       target;
    logic       has_remaining;
    logic [7:0] remaining_code;
  } out_beat_t;

  localparam logic [5:0]  FOREVER_STEPS = 6'h3f;
  localparam logic [7:0]  FOREVER_CODE  = 8'h3f;
  localparam logic [10:0] DELAY_UNIT_MS = 11'd5;

  // Step length of each resolution, in ms.
  localparam logic [25:0] RES_MS [4] = '{26'd100, 26'd1000, 26'd10000, 26'd600000};

  // Largest time that 62 steps of each resolution cover.
  localparam logic [26:0] LIMIT_MS [4] = '{27'd6200, 27'd62000, 27'd620000, 27'd37200000};

  // ceil(2^S / RES_MS) with S = 20, 26, 33, 45; exact for quotients below 63.
  localparam logic [25:0] RECIP [4] = '{26'd10486, 26'd67109, 26'd858994, 26'd58640621};

endpackage

### rtl/onoff_server_with_timed_transition.sv
// ----------------------------------------------------------------------------
// onoff_server_with_timed_transition: generic on/off server, 1 ms tick driven
// Stage 1 encodes a beat's status from the updated state; stage 2 holds it.
// Throughput: one beat per cycle unless the output stalls; state registers
// update once per beat, overlapping the stage 1 status encoding.
// Reset: asynchronous, active low; clears all state, both channels empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module onoff_server_with_timed_transition (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  onoff_pkg::in_beat_t   in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output onoff_pkg::out_beat_t  out_beat_o
);

  import onoff_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DELAY = 2'd1,
    PH_TRANS = 2'd2
  } phase_e;

  // Server state
  logic        value_q, value_d;
  logic [7:0]  last_tid_q, last_tid_d;
  logic [15:0] last_src_q, last_src_d;
  phase_e      phase_q, phase_d;
  logic [25:0] cd_q, cd_d;
  logic [25:0] pend_q, pend_d;
  logic        forever_q, forever_d;
  logic        led_q, led_d;

  // Pipeline: stage 1 holds the opcode of the beat whose state update is done,
  // stage 2 is the output register.
  logic        s1_valid_q, s1_valid_d;
  op_e         s1_op_q, s1_op_d;
  logic        out_valid_q, out_valid_d;
  out_beat_t   out_q, out_d;

  logic in_accept;
  logic out_accept;
  logic s2_load;

  // Stage 2 may load when the output slot is empty or is being emptied.
  assign out_accept = out_valid_q && !out_stall_i;
  assign s2_load    = s1_valid_q && (!out_valid_q || !out_stall_i);
  // Take a new beat only once the beat in stage 1 has read its state.
  assign in_stall_o = s1_valid_q && !s2_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Next state for the accepted beat
  // --------------------------------------------------------------------------
  logic [25:0] cd_dec;
  logic [7:0]  tcode;
  logic [7:0]  dcode;
  logic [5:0]  steps;
  logic        new_forever;
  logic [25:0] new_pend;
  logic [10:0] delay_ms;
  logic        set_taken;

  assign cd_dec   = (cd_q != '0) ? cd_q - 26'd1 : '0;
  assign tcode    = in_beat_i.has_timing ? in_beat_i.trans_code : '0;
  assign dcode    = in_beat_i.has_timing ? in_beat_i.delay_code : '0;
  assign steps    = tcode[5:0];
  assign new_forever = (steps == FOREVER_STEPS);
  // Step count times the step length of the chosen resolution.
  assign new_pend = new_forever ? '0 : 26'(steps) * RES_MS[tcode[7:6]];
  assign delay_ms = 11'(dcode) * DELAY_UNIT_MS;
  // Drop repeated transactions and sets that ask for the stored value.
  assign set_taken = !((in_beat_i.tid == last_tid_q) && (in_beat_i.src_addr == last_src_q))
                     && (in_beat_i.value != value_q);

  always_comb begin
    value_d    = value_q;
    last_tid_d = last_tid_q;
    last_src_d = last_src_q;
    phase_d    = phase_q;
    cd_d       = cd_q;
    pend_d     = pend_q;
    forever_d  = forever_q;
    led_d      = led_q;
    if (in_accept) begin
      case (in_beat_i.op) inside
        OP_TICK: begin
          unique case (phase_q)
            PH_DELAY: begin
              cd_d = cd_dec;
              if (cd_dec == '0) begin
                // Delay over: start the transition, or take the value now.
                if (forever_q || pend_q != '0) begin
                  led_d   = 1'b1;
                  phase_d = PH_TRANS;
                  cd_d    = pend_q;
                  pend_d  = '0;
                end else begin
                  led_d   = value_q;
                  phase_d = PH_IDLE;
                end
              end
            end
            PH_TRANS: begin
              // An endless transition holds until a new set arrives.
              if (!forever_q) begin
                cd_d = cd_dec;
                if (cd_dec == '0) begin
                  led_d   = value_q;
                  phase_d = PH_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
        OP_SET, OP_SET_UNACK: begin
          if (set_taken) begin
            value_d    = in_beat_i.value;
            last_tid_d = in_beat_i.tid;
            last_src_d = in_beat_i.src_addr;
            forever_d  = new_forever;
            if (dcode == '0) begin
              // Zero delay ends within this beat.
              if (new_forever || new_pend != '0) begin
                led_d   = 1'b1;
                phase_d = PH_TRANS;
                cd_d    = new_pend;
                pend_d  = '0;
              end else begin
                led_d   = in_beat_i.value;
                phase_d = PH_IDLE;
                cd_d    = '0;
                pend_d  = '0;
              end
            end else begin
              phase_d = PH_DELAY;
              cd_d    = 26'(delay_ms);
              pend_d  = new_pend;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Status of the beat in stage 1, built from the updated state
  // --------------------------------------------------------------------------
  logic        active;
  logic        endless;
  logic [26:0] rem;
  logic [1:0]  res_idx;
  logic        too_long;
  logic [26:0] rem_up;
  logic [51:0] prod;
  logic [5:0]  quot;
  logic [7:0]  rem_code;
  logic        is_status;

  assign active  = (phase_q == PH_DELAY) || (phase_q == PH_TRANS);
  assign endless = active && forever_q;
  assign rem     = !active ? '0
                 : {1'b0, cd_q} + ((phase_q == PH_DELAY) ? {1'b0, pend_q} : 27'd0);

  // Finest resolution whose 62 steps still cover the remaining time.
  always_comb begin
    too_long = 1'b0;
    if (rem <= LIMIT_MS[0]) begin
      res_idx = 2'd0;
    end else if (rem <= LIMIT_MS[1]) begin
      res_idx = 2'd1;
    end else if (rem <= LIMIT_MS[2]) begin
      res_idx = 2'd2;
    end else begin
      res_idx  = 2'd3;
      too_long = (rem > LIMIT_MS[3]);
    end
  end

  // Round up, then divide by the step length through its reciprocal.
  assign rem_up = rem + {1'b0, RES_MS[res_idx]} - 27'd1;
  assign prod   = 52'(rem_up[25:0]) * 52'(RECIP[res_idx]);

  always_comb begin
    case (res_idx)
      2'd0:    quot = prod[25:20];
      2'd1:    quot = prod[31:26];
      2'd2:    quot = prod[38:33];
      default: quot = prod[50:45];
    endcase
  end

  assign rem_code  = (endless || too_long) ? FOREVER_CODE : {res_idx, quot};
  assign is_status = (s1_op_q == OP_GET) || (s1_op_q == OP_SET);

  always_comb begin
    out_d = '0;
    out_d.led = led_q;
    if (is_status) begin
      out_d.status_valid = 1'b1;
      if (endless || rem != '0) begin
        out_d.present        = ~value_q;
        out_d.target         = value_q;
        out_d.has_remaining  = 1'b1;
        out_d.remaining_code = rem_code;
      end else begin
        out_d.present = value_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Handshake bookkeeping
  // --------------------------------------------------------------------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_op_d    = s1_op_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
      s1_op_d    = in_beat_i.op;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_load) begin
      out_valid_d = 1'b1;
    end else if (out_accept) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q     <= 1'b0;
      last_tid_q  <= '0;
      last_src_q  <= '0;
      phase_q     <= PH_IDLE;
      cd_q        <= '0;
      pend_q      <= '0;
      forever_q   <= 1'b0;
      led_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      s1_op_q     <= OP_TICK;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      value_q     <= value_d;
      last_tid_q  <= last_tid_d;
      last_src_q  <= last_src_d;
      phase_q     <= phase_d;
      cd_q        <= cd_d;
      pend_q      <= pend_d;
      forever_q   <= forever_d;
      led_q       <= led_d;
      s1_valid_q  <= s1_valid_d;
      s1_op_q     <= s1_op_d;
      out_valid_q <= out_valid_d;
      if (s2_load) begin
        out_q <= out_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef ASSERT_OFF
  // A running delay always has time left: a zero delay resolves at once.
  a_delay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DELAY |-> cd_q != '0)
    else $error("delay phase with empty countdown");

  // A timed transition in progress always has time left.
  a_trans_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TRANS && !forever_q) |-> cd_q != '0)
    else $error("timed transition with empty countdown");

  // An endless transition carries no pending time.
  a_forever_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    forever_q |-> pend_q == '0)
    else $error("pending time kept with endless transition");

  // A beat stalls at the input only behind a blocked output slot.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked output");
`endif

endmodule
